// ===== hw/rtl/fpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared constants for the fixed-partition fit allocator: request and status
// codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   localparam int MAX_BLOCKS_DEF = 32;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int FIELD_BITS = 16;   // width of the size fields on the ports
   localparam int INDEX_BITS = 5;    // width of the index field on the ports
   localparam int STATUS_BITS = 3;
   localparam int TOTAL_BITS = 21;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ALLOC  = 2'd1,
      REQ_REPORT = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   localparam logic [STATUS_BITS-1:0] ST_LOADED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_ALLOC   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOSPACE = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_REPORT  = 3'd4;

endpackage

// ===== hw/rtl/fixed_partition_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed-partition block table with first-fit / best-fit allocation and
// fragmentation reporting. Block sizes sit in a RAM that is scanned one entry
// per cycle; used marks, block count and the internal total sit in flops.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_stall | type, block size, proc size
//  rsp     | out       | rsp_valid / rsp_stall | status, index, leftover, totals
//  csr     | in        | csr_valid / csr_ready | fit mode (0 first, 1 best)
//
//  load and clear words go from idle straight to the emit state; allocate and
//  report words pass through the scan and finish states first (an empty table
//  skips the scan), scanning one entry a cycle through the block size RAM read port.
//  one word is in work at a time; req_stall is high until its result has been
//  moved into the output register, so a waiting result does not block the
//  next request word. reset is synchronous and empties the table and totals;
//  RAM contents are not cleared, only entries below the block count are read.
//
module fixed_partition_fit_allocator_core #(
   parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [fpfa_pkg::FIELD_BITS-1:0]     req_block_size,
   input  logic [fpfa_pkg::FIELD_BITS-1:0]     req_process_size,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fpfa_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [fpfa_pkg::INDEX_BITS-1:0]     rsp_block_index,
   output logic [fpfa_pkg::FIELD_BITS-1:0]     rsp_leftover,
   output logic [fpfa_pkg::TOTAL_BITS-1:0]     rsp_internal_total,
   output logic [fpfa_pkg::TOTAL_BITS-1:0]     rsp_external_total,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W  = (SIZE_BITS > fpfa_pkg::FIELD_BITS) ? SIZE_BITS
                                                              : fpfa_pkg::FIELD_BITS;
   localparam int SUM_W  = ((CMP_W > fpfa_pkg::TOTAL_BITS) ? CMP_W
                                                           : fpfa_pkg::TOTAL_BITS) + 1;
   localparam int TW     = fpfa_pkg::TOTAL_BITS;
   localparam int OIW    = fpfa_pkg::INDEX_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                  fit_mode_ff, fit_mode_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic [TW-1:0]         isum_ff, isum_in;

   logic [1:0]            op_ff, op_in;
   logic [fpfa_pkg::FIELD_BITS-1:0] psize_ff, psize_in;

   // scan pipeline: issue stage drives the RAM address, check stage sees data
   logic                  iss_on_ff, iss_on_in;
   logic [IDX_W-1:0]      iss_idx_ff, iss_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                  chk_used_ff, chk_used_in;
   logic                  chk_last_ff, chk_last_in;

   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  best_ff, best_in;
   logic [TW-1:0]         ext_ff, ext_in;

   // result waiting for the output register
   logic [fpfa_pkg::STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]                 res_idx_ff, res_idx_in;
   logic [fpfa_pkg::FIELD_BITS-1:0]  res_left_ff, res_left_in;
   logic [TW-1:0]                    res_itot_ff, res_itot_in;
   logic [TW-1:0]                    res_etot_ff, res_etot_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [fpfa_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [OIW-1:0]                   rsp_idx_ff, rsp_idx_in;
   logic [fpfa_pkg::FIELD_BITS-1:0]  rsp_left_ff, rsp_left_in;
   logic [TW-1:0]                    rsp_itot_ff, rsp_itot_in;
   logic [TW-1:0]                    rsp_etot_ff, rsp_etot_in;

   logic                  ram_we;
   logic                  ram_re;
   logic [SIZE_BITS-1:0]  ram_rd_data;

   logic                  rsp_fire;
   logic [CNT_W-1:0]      iss_next;
   logic                  iss_last;
   logic                  fits;
   logic                  take;
   logic [CMP_W-1:0]      left_w;
   logic [SUM_W-1:0]      isum_add;
   logic [SUM_W-1:0]      ext_add;
   logic [TW-1:0]         isum_sat;
   logic [TW-1:0]         ext_sat;
   logic [IDX_W+OIW-1:0]  res_idx_ext;

   // RAM writes happen only on a load word and reads only during a scan,
   // so the two never touch the same entry in overlapping cycles
   fpfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (SIZE_BITS'(req_block_size)),
      .rd_en   (ram_re),
      .rd_addr (iss_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_fire  = rsp_valid_ff & ~rsp_stall;
   assign iss_next  = CNT_W'(iss_idx_ff) + CNT_W'(1);
   assign iss_last  = (iss_next == count_ff);

   assign fits      = ~chk_used_ff & (CMP_W'(ram_rd_data) >= CMP_W'(psize_ff));
   assign take      = fits & (~found_ff | (fit_mode_ff & (ram_rd_data < best_ff)));

   assign left_w    = CMP_W'(best_ff) - CMP_W'(psize_ff);
   assign isum_add  = SUM_W'(isum_ff) + SUM_W'(left_w);
   assign isum_sat  = (isum_add > SUM_W'(fpfa_pkg::TOTAL_MAX)) ? fpfa_pkg::TOTAL_MAX
                                                               : isum_add[TW-1:0];
   assign ext_add   = SUM_W'(ext_ff) + SUM_W'(ram_rd_data);
   assign ext_sat   = (ext_add > SUM_W'(fpfa_pkg::TOTAL_MAX)) ? fpfa_pkg::TOTAL_MAX
                                                              : ext_add[TW-1:0];
   assign res_idx_ext = {{OIW{1'b0}}, res_idx_ff};

   always_comb begin
      state_in      = state_ff;
      fit_mode_in   = fit_mode_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      isum_in       = isum_ff;
      op_in         = op_ff;
      psize_in      = psize_ff;
      iss_on_in     = iss_on_ff;
      iss_idx_in    = iss_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      chk_used_in   = chk_used_ff;
      chk_last_in   = chk_last_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      ext_in        = ext_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_left_in   = res_left_ff;
      res_itot_in   = res_itot_ff;
      res_etot_in   = res_etot_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_fire;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_itot_in   = rsp_itot_ff;
      rsp_etot_in   = rsp_etot_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (csr_valid) begin
         fit_mode_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_type;
               psize_in    = req_process_size;
               res_idx_in  = '0;
               res_left_in = '0;
               res_etot_in = '0;
               res_itot_in = isum_ff;
               unique case (req_type) inside
                  fpfa_pkg::REQ_LOAD: begin
                     if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                        res_status_in = fpfa_pkg::ST_FULL;
                     end else begin
                        ram_we                        = 1'b1;
                        used_in[count_ff[IDX_W-1:0]]  = 1'b0;
                        count_in                      = count_ff + CNT_W'(1);
                        res_status_in                 = fpfa_pkg::ST_LOADED;
                        res_idx_in                    = count_ff[IDX_W-1:0];
                     end
                     state_in = S_EMIT;
                  end
                  fpfa_pkg::REQ_ALLOC, fpfa_pkg::REQ_REPORT: begin
                     found_in   = 1'b0;
                     ext_in     = '0;
                     iss_idx_in = '0;
                     if (count_ff == '0) begin
                        iss_on_in = 1'b0;
                        state_in  = S_FINISH;
                     end else begin
                        iss_on_in = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     // clear: fit mode survives, the RAM is left as is
                     used_in       = '0;
                     count_in      = '0;
                     isum_in       = '0;
                     res_itot_in   = '0;
                     res_status_in = fpfa_pkg::ST_REPORT;
                     state_in      = S_EMIT;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (iss_on_ff) begin
               ram_re      = 1'b1;
               chk_vld_in  = 1'b1;
               chk_idx_in  = iss_idx_ff;
               chk_used_in = used_ff[iss_idx_ff];
               chk_last_in = iss_last;
               if (iss_last) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + IDX_W'(1);
               end
            end
            if (chk_vld_ff) begin
               if (take) begin
                  found_in = 1'b1;
                  pick_in  = chk_idx_ff;
                  best_in  = ram_rd_data;
               end
               if (~chk_used_ff) begin
                  ext_in = ext_sat;
               end
               if (chk_last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (op_ff == fpfa_pkg::REQ_ALLOC) begin
               if (found_ff) begin
                  used_in[pick_ff] = 1'b1;
                  isum_in          = isum_sat;
                  res_status_in    = fpfa_pkg::ST_ALLOC;
                  res_idx_in       = pick_ff;
                  res_left_in      = left_w[fpfa_pkg::FIELD_BITS-1:0];
                  res_itot_in      = isum_sat;
               end else begin
                  res_status_in    = fpfa_pkg::ST_NOSPACE;
               end
            end else begin
               res_status_in = fpfa_pkg::ST_REPORT;
               res_etot_in   = ext_ff;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (~rsp_valid_ff | rsp_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ext[OIW-1:0];
               rsp_left_in   = res_left_ff;
               rsp_itot_in   = res_itot_ff;
               rsp_etot_in   = res_etot_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fit_mode_ff  <= 1'b0;
         count_ff     <= '0;
         used_ff      <= '0;
         isum_ff      <= '0;
         iss_on_ff    <= 1'b0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fit_mode_ff  <= fit_mode_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         isum_ff      <= isum_in;
         iss_on_ff    <= iss_on_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      psize_ff      <= psize_in;
      iss_idx_ff    <= iss_idx_in;
      chk_idx_ff    <= chk_idx_in;
      chk_used_ff   <= chk_used_in;
      chk_last_ff   <= chk_last_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      ext_ff        <= ext_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_left_ff   <= res_left_in;
      res_itot_ff   <= res_itot_in;
      res_etot_ff   <= res_etot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_itot_ff   <= rsp_itot_in;
      rsp_etot_ff   <= rsp_etot_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_block_index    = rsp_idx_ff;
   assign rsp_leftover       = rsp_left_ff;
   assign rsp_internal_total = rsp_itot_ff;
   assign rsp_external_total = rsp_etot_ff;

endmodule

// ===== hw/rtl/fpfa_ram.sv =====
// ----------------------------------------------------------------------------
// fpfa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/fixed_partition_fit_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core_tb
// Self-checking bench for the fixed-partition allocator. A short table of
// directed request words comes first. After it come random episodes: a clear,
// a burst of block loads, then allocations, reports and noise. Every result
// word is checked field by field against a pinned directed row or a local model
// of the block table, under both fit modes and several patterns of idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_core_tb;

   localparam int STATUS_BITS  = fpfa_pkg::STATUS_BITS;
   localparam int INDEX_BITS   = fpfa_pkg::INDEX_BITS;
   localparam int FIELD_BITS   = fpfa_pkg::FIELD_BITS;
   localparam int TOTAL_BITS   = fpfa_pkg::TOTAL_BITS;
   localparam int SIZE_BITS    = fpfa_pkg::SIZE_BITS_DEF;
   localparam int TABLE_DEPTH  = fpfa_pkg::MAX_BLOCKS_DEF;
   localparam int SETTLE_CYCLES = fpfa_pkg::MAX_BLOCKS_DEF + 8;
   localparam int MODE_KEEP    = -1;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  index;
      logic [FIELD_BITS-1:0]  leftover;
      logic [TOTAL_BITS-1:0]  internal_total;
      logic [TOTAL_BITS-1:0]  external_total;
   } alloc_result_type;

   typedef struct {
      int                     mode;
      fpfa_pkg::req_code_type kind;
      logic [FIELD_BITS-1:0]  block_size;
      logic [FIELD_BITS-1:0]  process_size;
      bit                     pinned;
      alloc_result_type       result;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_type = 2'd0;
   logic [FIELD_BITS-1:0]  req_block_size = '0;
   logic [FIELD_BITS-1:0]  req_process_size = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [INDEX_BITS-1:0]  rsp_block_index;
   logic [FIELD_BITS-1:0]  rsp_leftover;
   logic [TOTAL_BITS-1:0]  rsp_internal_total;
   logic [TOTAL_BITS-1:0]  rsp_external_total;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_data = 1'b0;

   // local copy of the block table
   logic [SIZE_BITS-1:0]     tbl_size [TABLE_DEPTH];
   bit                       tbl_used [TABLE_DEPTH];
   int                       tbl_count = 0;
   logic [TOTAL_BITS-1:0]    frag_internal = '0;
   logic                     best_fit_mode = 1'b0;

   alloc_result_type owed_results[$];
   alloc_result_type predicted;
   alloc_result_type oldest;
   bit               pin_on = 1'b0;
   alloc_result_type pin_word = '0;
   directed_row_type directed_rows[$];

   int  mismatch_count = 0;
   int  words_sent = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;

   fixed_partition_fit_allocator_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_block_size     (req_block_size),
      .req_process_size   (req_process_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_block_index    (rsp_block_index),
      .rsp_leftover       (rsp_leftover),
      .rsp_internal_total (rsp_internal_total),
      .rsp_external_total (rsp_external_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [TOTAL_BITS-1:0] sat_sum(input logic [TOTAL_BITS-1:0] a,
                                                     input logic [FIELD_BITS-1:0] b);
      logic [TOTAL_BITS:0] s;
      s = {1'b0, a} + (TOTAL_BITS+1)'(b);
      return (s > {1'b0, fpfa_pkg::TOTAL_MAX}) ? fpfa_pkg::TOTAL_MAX : s[TOTAL_BITS-1:0];
   endfunction

   function automatic void predict_allocation(input fpfa_pkg::req_code_type kind,
                                              input logic [FIELD_BITS-1:0] bsz,
                                              input logic [FIELD_BITS-1:0] psz,
                                              output alloc_result_type res);
      int                    n;
      int                    pick;
      bit                    found;
      logic [TOTAL_BITS-1:0] ext;
      res = '0;
      n = (tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : tbl_count;
      pick = 0;
      found = 1'b0;
      ext = '0;
      case (kind)
         fpfa_pkg::REQ_LOAD: begin
            if (n >= TABLE_DEPTH) begin
               res.status = fpfa_pkg::ST_FULL;
            end else begin
               tbl_size[n] = bsz;
               tbl_used[n] = 1'b0;
               tbl_count = n + 1;
               res.status = fpfa_pkg::ST_LOADED;
               res.index = INDEX_BITS'(n);
            end
         end
         fpfa_pkg::REQ_ALLOC: begin
            for (int i = 0; i < n; i++) begin
               if (!tbl_used[i] && tbl_size[i] >= psz) begin
                  if (!found) begin
                     found = 1'b1;
                     pick = i;
                  end else if (best_fit_mode && tbl_size[i] < tbl_size[pick]) begin
                     pick = i;
                  end
               end
            end
            if (!found) begin
               res.status = fpfa_pkg::ST_NOSPACE;
            end else begin
               tbl_used[pick] = 1'b1;
               res.status = fpfa_pkg::ST_ALLOC;
               res.index = INDEX_BITS'(pick);
               res.leftover = tbl_size[pick] - psz;
               frag_internal = sat_sum(frag_internal, res.leftover);
            end
         end
         fpfa_pkg::REQ_REPORT: begin
            for (int i = 0; i < n; i++)
               if (!tbl_used[i]) ext = sat_sum(ext, tbl_size[i]);
            res.status = fpfa_pkg::ST_REPORT;
            res.external_total = ext;
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               tbl_size[i] = '0;
               tbl_used[i] = 1'b0;
            end
            tbl_count = 0;
            frag_internal = '0;
            res.status = fpfa_pkg::ST_REPORT;
         end
      endcase
      res.internal_total = frag_internal;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // outputs and handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_allocation(fpfa_pkg::req_code_type'(req_type), req_block_size,
                               req_process_size, predicted);
            owed_results.push_back(pin_on ? pin_word : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result word", 32'(rsp_status), 32'd0);
            end else begin
               oldest = owed_results.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch("status", 32'(rsp_status), 32'(oldest.status));
               if (rsp_block_index !== oldest.index)
                  report_mismatch("block_index", 32'(rsp_block_index), 32'(oldest.index));
               if (rsp_leftover !== oldest.leftover)
                  report_mismatch("leftover", 32'(rsp_leftover), 32'(oldest.leftover));
               if (rsp_internal_total !== oldest.internal_total)
                  report_mismatch("internal_total", 32'(rsp_internal_total),
                                  32'(oldest.internal_total));
               if (rsp_external_total !== oldest.external_total)
                  report_mismatch("external_total", 32'(rsp_external_total),
                                  32'(oldest.external_total));
            end
         end
         if (csr_valid && csr_ready) best_fit_mode = csr_data;
      end
   end

   // receiver side: random stall, or one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic send_word(input fpfa_pkg::req_code_type kind,
                            input logic [FIELD_BITS-1:0] bsz,
                            input logic [FIELD_BITS-1:0] psz, input bit pin,
                            input alloc_result_type pinned);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_block_size <= bsz;
      req_process_size <= psz;
      pin_on <= pin;
      pin_word <= pinned;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // only while the block is idle
   task automatic drain_and_configure(input logic mode);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_block_size();
      case ($urandom_range(0, 7))
         0, 1:    return FIELD_BITS'($urandom);
         2, 3:    return FIELD_BITS'($urandom_range(1, 16) * 16);  // repeats for ties
         4, 5, 6: return FIELD_BITS'($urandom_range(0, 1023));
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   // mostly aimed at a stored block so allocations land
   function automatic logic [FIELD_BITS-1:0] pick_process_size();
      int                    j;
      int                    d;
      logic [FIELD_BITS-1:0] s;
      if (tbl_count == 0 || $urandom_range(0, 3) == 0) return FIELD_BITS'($urandom);
      j = $urandom_range(0, tbl_count - 1);
      s = tbl_size[j];
      case ($urandom_range(0, 3))
         0: return s;
         1: begin
            d = $urandom_range(0, (s < 64) ? int'(s) : 64);
            return s - FIELD_BITS'(d);
         end
         2: return (s == '1) ? s : s + FIELD_BITS'(1);
         default: return FIELD_BITS'($urandom_range(0, int'(s)));
      endcase
   endfunction

   task automatic run_episode();
      int loads;
      int ops;
      int r;
      loads = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 12);
      send_word(fpfa_pkg::REQ_CLEAR, FIELD_BITS'($urandom), FIELD_BITS'($urandom), 1'b0, '0);
      repeat (loads)
         send_word(fpfa_pkg::REQ_LOAD, pick_block_size(), FIELD_BITS'($urandom), 1'b0, '0);
      ops = $urandom_range(4, loads + 8);
      repeat (ops) begin
         r = $urandom_range(0, 99);
         if (r < 62)
            send_word(fpfa_pkg::REQ_ALLOC, FIELD_BITS'($urandom), pick_process_size(),
                      1'b0, '0);
         else if (r < 78)
            send_word(fpfa_pkg::REQ_REPORT, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                      1'b0, '0);
         else if (r < 90)
            send_word(fpfa_pkg::REQ_LOAD, pick_block_size(), FIELD_BITS'($urandom),
                      1'b0, '0);
         else
            send_word(fpfa_pkg::req_code_type'($urandom_range(0, 3)), FIELD_BITS'($urandom),
                      FIELD_BITS'($urandom), 1'b0, '0);
      end
   endtask

   task automatic run_phase(input int target, input int send_pct, input int stall_pct,
                            input logic mode, input bit pressure);
      int start;
      drain_and_configure(mode);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (pressure) hold_request = 1'b1;
      start = words_sent;
      while (words_sent - start < target) run_episode();
   endtask

   task automatic add_row(input int mode, input fpfa_pkg::req_code_type kind,
                          input logic [FIELD_BITS-1:0] bsz, input logic [FIELD_BITS-1:0] psz,
                          input bit pin, input logic [STATUS_BITS-1:0] st,
                          input int idx, input int left, input int itot, input int etot);
      directed_row_type row;
      row.mode = mode;
      row.kind = kind;
      row.block_size = bsz;
      row.process_size = psz;
      row.pinned = pin;
      row.result = '{st, INDEX_BITS'(idx), FIELD_BITS'(left), TOTAL_BITS'(itot),
                     TOTAL_BITS'(etot)};
      directed_rows.push_back(row);
   endtask

   initial begin : stimulus
      int guard;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first fit after reset
      add_row(MODE_KEEP, fpfa_pkg::REQ_REPORT, 16'h0000, 16'h0000, 1'b1,
              fpfa_pkg::ST_REPORT, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'h0000, 16'h0000, 1'b1,
              fpfa_pkg::ST_NOSPACE, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'hFFFF, 16'hFFFF, 1'b1,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'h0000, 16'h0000, 1'b1,
              fpfa_pkg::ST_LOADED, 1, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd100, 16'd0, 1'b1,
              fpfa_pkg::ST_LOADED, 2, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd300, 16'd0, 1'b1,
              fpfa_pkg::ST_LOADED, 3, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd200, 16'd0, 1'b1,
              fpfa_pkg::ST_LOADED, 4, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_REPORT, 16'd0, 16'd0, 1'b1,
              fpfa_pkg::ST_REPORT, 0, 0, 0, 66135);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd150, 1'b1,
              fpfa_pkg::ST_ALLOC, 0, 65385, 65385, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd0, 1'b1,
              fpfa_pkg::ST_ALLOC, 1, 0, 65385, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'hFFFF, 1'b1,
              fpfa_pkg::ST_NOSPACE, 0, 0, 65385, 0);
      // first fit takes the 300 block even though 200 fits tighter
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd150, 1'b1,
              fpfa_pkg::ST_ALLOC, 3, 150, 65535, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_REPORT, 16'd0, 16'd0, 1'b1,
              fpfa_pkg::ST_REPORT, 0, 0, 65535, 300);
      add_row(MODE_KEEP, fpfa_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1,
              fpfa_pkg::ST_REPORT, 0, 0, 0, 0);
      // best fit, ties to the lowest index
      add_row(1, fpfa_pkg::REQ_LOAD, 16'd300, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd100, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd100, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'hFFFF, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_LOAD, 16'd150, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd100, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd50, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd120, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'd1, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_REPORT, 16'd0, 16'd0, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);
      add_row(MODE_KEEP, fpfa_pkg::REQ_ALLOC, 16'd0, 16'hFFFF, 1'b0,
              fpfa_pkg::ST_LOADED, 0, 0, 0, 0);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].mode != MODE_KEEP)
            drain_and_configure(directed_rows[k].mode[0]);
         send_word(directed_rows[k].kind, directed_rows[k].block_size,
                   directed_rows[k].process_size, directed_rows[k].pinned,
                   directed_rows[k].result);
      end

      run_phase(200, 0, 0, 1'b1, 1'b0);
      run_phase(200, 76, 0, 1'b0, 1'b0);
      run_phase(200, 0, 76, 1'b1, 1'b0);
      run_phase(200, 13, 13, 1'b0, 1'b0);
      // long receiver hold-off while words keep coming
      run_phase(150, 0, 0, 1'($urandom_range(0, 1)), 1'b1);
      run_phase(200, 13, 13, 1'b1, 1'b0);

      req_valid <= 1'b0;
      guard = 0;
      while (owed_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_results.size() != 0)
         report_mismatch("results never returned", 32'(owed_results.size()), 32'd0);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fpfa_pkg.sv
hw/rtl/fpfa_ram.sv
hw/rtl/fixed_partition_fit_allocator_core.sv
test/fixed_partition_fit_allocator_core_tb.sv
